[hdl/tcpra_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcpra_pkg;

   localparam int PENDING_DEPTH = 16;
   localparam int MAX_PAYLOAD   = 1024;

   localparam int SEQ_W = 32;
   localparam int LEN_W = 11;
   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_DELIVER = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   typedef struct packed {
      logic [SEQ_W-1:0] seg_seq;
      logic [LEN_W-1:0] seg_len;
   } req_type;

   typedef struct packed {
      kind_type         kind;
      logic [SEQ_W-1:0] out_seq;
      logic [LEN_W-1:0] out_len;
      logic [SEQ_W-1:0] ack_value;
      logic             dropped;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [SEQ_W-1:0] seq;
      logic [LEN_W-1:0] len;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DUP,
      ST_INS,
      ST_DRAIN,
      ST_PURGE,
      ST_ACK
   } state_type;

   // modular compare: seq lies behind the expected byte number
   function automatic logic is_behind(input logic [SEQ_W-1:0] seq,
                                      input logic [SEQ_W-1:0] expected);
      logic [SEQ_W-1:0] diff;
      diff = seq - expected;
      return diff[SEQ_W-1];
   endfunction

endpackage

`default_nettype wire

[hdl/tcpra_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcpra_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift_en,
   input  wire tcpra_pkg::entry_type entry_prev,
   output tcpra_pkg::entry_type      entry_out
);
   import tcpra_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (shift_en) begin
         entry_ff <= entry_prev;
      end
   end

   assign entry_out = entry_ff;

endmodule

`default_nettype wire

[hdl/tcp_receive_reorder_ack.sv]
`timescale 1ns / 1ps
`default_nettype none

// Receive-side segment reorder and cumulative ack. Each header word accepted before end of stream
// gives one or more result words; the last one of each burst has last set. Pending out-of-order
// segments sit in a ring of PENDING_DEPTH cells that rotates past a single inspection point at its
// tail, one place per cycle while a store walk runs and no delivery waits, so every store
// operation is a walk around the ring. Work per header: end of stream, oversize and stale headers
// are answered from idle without touching the store; a duplicate or a header that finds the store
// full takes one revolution for the duplicate check, then the ack; any other out-of-order header
// takes that revolution plus up to one more to find a free cell, then the ack; an in-order header
// walks the ring until a full revolution finds no follow-on segment, then one more revolution
// discards stale entries, then the ack. A delivery stalls the walk when the result side holds
// off ready. After end of stream every header is taken and ignored.
module tcp_receive_reorder_ack (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire tcpra_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output tcpra_pkg::rsp_type      rsp_data
);
   import tcpra_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SEQ_W-1:0] exp_ff, exp_in;
   logic             done_ff, done_in;
   logic [SEQ_W-1:0] hold_seq_ff, hold_seq_in;
   logic [LEN_W-1:0] hold_len_ff, hold_len_in;
   logic             dup_ff, dup_in;
   logic             free_ff, free_in;
   logic             drop_ff, drop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   entry_type        cell_q [PENDING_DEPTH];
   entry_type        head_in;
   entry_type        tail;
   logic             shift_en;
   logic             out_free;
   logic             accept;
   logic             rsp_load;
   rsp_type          rsp_next;
   logic             tail_match;
   logic             pass_end;
   logic [SEQ_W-1:0] exp_plus_req;
   logic [SEQ_W-1:0] exp_plus_tail;

   genvar g;
   generate
      for (g = 0; g < PENDING_DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_head
            tcpra_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .shift_en   (shift_en),
               .entry_prev (head_in),
               .entry_out  (cell_q[g])
            );
         end else begin : g_body
            tcpra_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .shift_en   (shift_en),
               .entry_prev (cell_q[g-1]),
               .entry_out  (cell_q[g])
            );
         end
      end
   endgenerate

   assign tail          = cell_q[PENDING_DEPTH-1];
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == ST_IDLE) && out_free;
   assign accept        = req_valid && req_ready;
   assign exp_plus_req  = exp_ff + SEQ_W'(req_data.seg_len);
   assign exp_plus_tail = exp_ff + SEQ_W'(tail.len);
   assign tail_match    = tail.valid && (tail.seq == exp_ff);
   assign pass_end      = (cnt_ff == CNT_W'(PENDING_DEPTH - 1));

   function automatic rsp_type make_rsp(input kind_type k, input logic [SEQ_W-1:0] s,
                                        input logic [LEN_W-1:0] l,
                                        input logic [SEQ_W-1:0] a, input logic d,
                                        input logic lst);
      rsp_type r;
      r.kind      = k;
      r.out_seq   = s;
      r.out_len   = l;
      r.ack_value = a;
      r.dropped   = d;
      r.last      = lst;
      return r;
   endfunction

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      exp_in      = exp_ff;
      done_in     = done_ff;
      hold_seq_in = hold_seq_ff;
      hold_len_in = hold_len_ff;
      dup_in      = dup_ff;
      free_in     = free_ff;
      drop_in     = drop_ff;
      shift_en    = 1'b0;
      head_in     = tail;
      rsp_load    = 1'b0;
      rsp_next    = make_rsp(KIND_ACK, '0, '0, exp_ff, 1'b0, 1'b1);

      case (state_ff)
         ST_IDLE: begin
            if (accept && !done_ff) begin
               if (req_data.seg_len == '0) begin
                  done_in  = 1'b1;
                  rsp_load = 1'b1;
                  rsp_next = make_rsp(KIND_END, '0, '0, exp_ff, 1'b0, 1'b1);
               end else if (req_data.seg_len > LEN_W'(MAX_PAYLOAD)) begin
                  rsp_load = 1'b1;
               end else if (req_data.seg_seq == exp_ff) begin
                  rsp_load = 1'b1;
                  rsp_next = make_rsp(KIND_DELIVER, req_data.seg_seq, req_data.seg_len,
                                      exp_plus_req, 1'b0, 1'b0);
                  exp_in   = exp_plus_req;
                  cnt_in   = '0;
                  state_in = ST_DRAIN;
               end else if (is_behind(req_data.seg_seq, exp_ff)) begin
                  rsp_load = 1'b1;
               end else begin
                  hold_seq_in = req_data.seg_seq;
                  hold_len_in = req_data.seg_len;
                  dup_in      = 1'b0;
                  free_in     = 1'b0;
                  cnt_in      = '0;
                  state_in    = ST_DUP;
               end
            end
         end

         // one revolution: look for a duplicate and for any free cell
         ST_DUP: begin
            shift_en = 1'b1;
            dup_in   = dup_ff || (tail.valid && (tail.seq == hold_seq_ff));
            free_in  = free_ff || !tail.valid;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (pass_end) begin
               cnt_in = '0;
               if (dup_in) begin
                  drop_in  = 1'b0;
                  state_in = ST_ACK;
               end else if (!free_in) begin
                  drop_in  = 1'b1;
                  state_in = ST_ACK;
               end else begin
                  state_in = ST_INS;
               end
            end
         end

         // rotate until a free cell passes the tail, then fill it
         ST_INS: begin
            shift_en = 1'b1;
            if (!tail.valid) begin
               head_in.valid = 1'b1;
               head_in.seq   = hold_seq_ff;
               head_in.len   = hold_len_ff;
               drop_in       = 1'b0;
               state_in      = ST_ACK;
            end
         end

         // deliver follow-on segments until a full revolution has no match
         ST_DRAIN: begin
            if (tail_match) begin
               if (out_free) begin
                  shift_en      = 1'b1;
                  head_in.valid = 1'b0;
                  exp_in        = exp_plus_tail;
                  cnt_in        = '0;
                  rsp_load      = 1'b1;
                  rsp_next      = make_rsp(KIND_DELIVER, tail.seq, tail.len, exp_plus_tail,
                                           1'b0, 1'b0);
               end
            end else begin
               shift_en = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
               if (pass_end) begin
                  cnt_in   = '0;
                  state_in = ST_PURGE;
               end
            end
         end

         // free entries left behind the final expected number
         ST_PURGE: begin
            shift_en = 1'b1;
            if (tail.valid && is_behind(tail.seq, exp_ff)) begin
               head_in.valid = 1'b0;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (pass_end) begin
               cnt_in   = '0;
               drop_in  = 1'b0;
               state_in = ST_ACK;
            end
         end

         ST_ACK: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_next = make_rsp(KIND_ACK, '0, '0, exp_ff, drop_ff, 1'b1);
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         exp_ff       <= '0;
         done_ff      <= 1'b0;
         dup_ff       <= 1'b0;
         free_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         exp_ff       <= exp_in;
         done_ff      <= done_in;
         dup_ff       <= dup_in;
         free_ff      <= free_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_seq_ff <= hold_seq_in;
      hold_len_ff <= hold_len_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[tb/tcp_receive_reorder_ack_test.sv]
`timescale 1ns / 1ps

module tcp_receive_reorder_ack_test;
   import tcpra_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int TAIL_CYCLES  = 80;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 440;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   tcp_receive_reorder_ack dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data
   );

   // receive-side state as the testbench sees it
   logic [SEQ_W-1:0] next_byte;
   logic [SEQ_W-1:0] held_seq [PENDING_DEPTH];
   logic [LEN_W-1:0] held_len [PENDING_DEPTH];
   logic             held_used [PENDING_DEPTH];
   logic             stream_closed;

   rsp_type burst_words[$];
   rsp_type awaited_words[$];

   typedef struct {
      logic [SEQ_W-1:0] seq;
      logic [LEN_W-1:0] len;
      bit               fixed;
      logic [SEQ_W-1:0] fixed_ack;
      logic             fixed_drop;
   } seg_row_type;

   seg_row_type directed_rows[$];

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_start;
   int hold_left;
   int failures;
   int accepted;
   int results_seen;
   int deliveries;
   int drops_seen;
   int cycles;

   function automatic rsp_type make_word(kind_type k, logic [SEQ_W-1:0] s,
                                         logic [LEN_W-1:0] l, logic [SEQ_W-1:0] a,
                                         logic d, logic f);
      rsp_type w;
      w.kind      = k;
      w.out_seq   = s;
      w.out_len   = l;
      w.ack_value = a;
      w.dropped   = d;
      w.last      = f;
      return w;
   endfunction

   function automatic logic behind_next(logic [SEQ_W-1:0] s);
      logic [SEQ_W-1:0] diff;
      diff = s - next_byte;
      return diff[SEQ_W-1];
   endfunction

   // works out the result words of one accepted header into burst_words
   function automatic void reassemble(logic [SEQ_W-1:0] s, logic [LEN_W-1:0] l);
      int   slot;
      logic hit;
      logic dup;
      logic drop;
      burst_words.delete();
      if (stream_closed)
         return;
      if (l == '0) begin
         stream_closed = 1'b1;
         burst_words.push_back(make_word(KIND_END, '0, '0, next_byte, 1'b0, 1'b1));
         return;
      end
      if (l > LEN_W'(MAX_PAYLOAD)) begin
         burst_words.push_back(make_word(KIND_ACK, '0, '0, next_byte, 1'b0, 1'b1));
         return;
      end
      if (s == next_byte) begin
         next_byte = next_byte + SEQ_W'(l);
         burst_words.push_back(make_word(KIND_DELIVER, s, l, next_byte, 1'b0, 1'b0));
         hit = 1'b1;
         while (hit) begin
            hit = 1'b0;
            for (int i = 0; i < PENDING_DEPTH && !hit; i++) begin
               if (held_used[i] && held_seq[i] == next_byte) begin
                  held_used[i] = 1'b0;
                  next_byte = next_byte + SEQ_W'(held_len[i]);
                  burst_words.push_back(make_word(KIND_DELIVER, held_seq[i], held_len[i],
                                                  next_byte, 1'b0, 1'b0));
                  hit = 1'b1;
               end
            end
         end
         // stale entries that the stream has now passed
         for (int i = 0; i < PENDING_DEPTH; i++) begin
            if (held_used[i] && behind_next(held_seq[i]))
               held_used[i] = 1'b0;
         end
         burst_words.push_back(make_word(KIND_ACK, '0, '0, next_byte, 1'b0, 1'b1));
         return;
      end
      dup  = 1'b0;
      drop = 1'b0;
      slot = -1;
      if (!behind_next(s)) begin
         for (int i = 0; i < PENDING_DEPTH; i++) begin
            if (held_used[i]) begin
               if (held_seq[i] == s)
                  dup = 1'b1;
            end else if (slot < 0) begin
               slot = i;
            end
         end
         if (!dup) begin
            if (slot >= 0) begin
               held_seq[slot]  = s;
               held_len[slot]  = l;
               held_used[slot] = 1'b1;
            end else begin
               drop = 1'b1;
            end
         end
      end
      burst_words.push_back(make_word(KIND_ACK, '0, '0, next_byte, drop, 1'b1));
   endfunction

   function automatic void add_row(logic [SEQ_W-1:0] s, logic [LEN_W-1:0] l, bit fixed,
                                   logic [SEQ_W-1:0] ack, logic drop);
      seg_row_type r;
      r.seq        = s;
      r.len        = l;
      r.fixed      = fixed;
      r.fixed_ack  = ack;
      r.fixed_drop = drop;
      directed_rows.push_back(r);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer(logic [SEQ_W-1:0] s, logic [LEN_W-1:0] l, bit fixed,
                        logic [SEQ_W-1:0] fixed_ack, logic fixed_drop);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{seg_seq: s, seg_len: l};
      do @(posedge clock); while (!req_ready);
      reassemble(s, l);
      if (fixed) begin
         burst_words.delete();
         burst_words.push_back(make_word(KIND_ACK, '0, '0, fixed_ack, fixed_drop, 1'b1));
      end
      foreach (burst_words[k])
         awaited_words.push_back(burst_words[k]);
      accepted++;
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d words still awaited", cycles,
               awaited_words.size());
      $display("end of test: mismatches");
      $finish;
   end

   // result side: random ready, plus one long hold-off on request
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      hold_left  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : watch_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (awaited_words.size() == 0) begin
            $error("unexpected result word: kind %0d ack %0h", rsp_data.kind,
                   rsp_data.ack_value);
            failures++;
         end else begin
            want = awaited_words.pop_front();
            if (rsp_data.kind != want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_data.kind);
               failures++;
            end
            if (rsp_data.out_seq != want.out_seq) begin
               $error("out_seq: expected %0h, got %0h", want.out_seq, rsp_data.out_seq);
               failures++;
            end
            if (rsp_data.out_len != want.out_len) begin
               $error("out_len: expected %0d, got %0d", want.out_len, rsp_data.out_len);
               failures++;
            end
            if (rsp_data.ack_value != want.ack_value) begin
               $error("ack_value: expected %0h, got %0h", want.ack_value,
                      rsp_data.ack_value);
               failures++;
            end
            if (rsp_data.dropped != want.dropped) begin
               $error("dropped: expected %0b, got %0b", want.dropped, rsp_data.dropped);
               failures++;
            end
            if (rsp_data.last != want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_data.last);
               failures++;
            end
            if (want.kind == KIND_DELIVER)
               deliveries++;
            if (want.dropped)
               drops_seen++;
         end
      end
   end

   initial begin
      req_type          plan[$];
      req_type          swap;
      int               n;
      int               j;
      int               sent_random;
      bit               hold_done;
      logic [SEQ_W-1:0] cursor;
      logic [SEQ_W-1:0] noise_seq;
      logic [LEN_W-1:0] seg_bytes;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 34;
      recv_idle_pct = 61;
      hold_start    = 1'b0;
      failures      = 0;
      accepted      = 0;
      results_seen  = 0;
      deliveries    = 0;
      drops_seen    = 0;
      next_byte     = '0;
      stream_closed = 1'b0;
      foreach (held_used[i]) begin
         held_used[i] = 1'b0;
         held_seq[i]  = '0;
         held_len[i]  = '0;
      end

      // directed: ack-only rows carry their ack, the rest go through the predictor
      add_row(32'd100, 11'd50, 1, 32'd0, 1'b0);        // ahead, kept
      add_row(32'd100, 11'd50, 1, 32'd0, 1'b0);        // duplicate of a kept word
      add_row(32'hFFFF_FFF0, 11'd16, 1, 32'd0, 1'b0);  // just behind
      add_row(32'h8000_0000, 11'd8, 1, 32'd0, 1'b0);   // half the space away counts as behind
      add_row(32'd0, 11'd1025, 1, 32'd0, 1'b0);        // oversize
      add_row(32'd0, 11'h7FF, 1, 32'd0, 1'b0);         // largest length field
      add_row(32'd0, 11'd100, 0, '0, 1'b0);            // in order, pulls the kept word
      add_row(32'h7FFF_FFFF, 11'd1, 1, 32'd150, 1'b0); // far ahead, under half the space away
      for (int k = 0; k < 14; k++)
         add_row(32'(200 + 4 * k), 11'd4, 1, 32'd150, 1'b0);
      add_row(32'd221, 11'd3, 1, 32'd150, 1'b0);       // overlaps the chain, later stale
      add_row(32'd5000, 11'd8, 1, 32'd150, 1'b1);      // store full
      add_row(32'd150, 11'd50, 0, '0, 1'b0);           // fills the gap, long drain
      add_row(32'd256, 11'd1024, 0, '0, 1'b0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[k])
         offer(directed_rows[k].seq, directed_rows[k].len, directed_rows[k].fixed,
               directed_rows[k].fixed_ack, directed_rows[k].fixed_drop);

      sent_random = 0;
      hold_done   = 1'b0;
      while (sent_random < RANDOM_ITEMS) begin
         // a run of back-to-back segments from the next expected byte
         n = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 10);
         cursor = next_byte;
         plan.delete();
         for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
               0: seg_bytes = LEN_W'(MAX_PAYLOAD);
               1: seg_bytes = LEN_W'($urandom_range(1, MAX_PAYLOAD));
               2: seg_bytes = 11'd1;
               default: seg_bytes = LEN_W'($urandom_range(1, 48));
            endcase
            plan.push_back('{seg_seq: cursor, seg_len: seg_bytes});
            cursor = cursor + SEQ_W'(seg_bytes);
         end
         if ($urandom_range(3) != 0) begin
            for (int k = n - 1; k > 0; k--) begin
               j       = $urandom_range(k);
               swap    = plan[k];
               plan[k] = plan[j];
               plan[j] = swap;
            end
         end
         for (int k = 0; k < n; k++) begin
            if (sent_random < RANDOM_ITEMS / 3) begin
               send_idle_pct = 34;
               recv_idle_pct = 61;
            end else if (sent_random < 2 * RANDOM_ITEMS / 3) begin
               send_idle_pct = 61;
               recv_idle_pct = 34;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               if (!hold_done) begin
                  hold_done  = 1'b1;
                  hold_start = 1'b1;
               end
            end
            if ($urandom_range(9) == 0) begin
               case ($urandom_range(2))
                  0: begin
                     noise_seq = $urandom;
                     seg_bytes = LEN_W'($urandom_range(MAX_PAYLOAD + 1, 2047));
                  end
                  1: begin
                     // random word pushed behind so the store does not silt up
                     noise_seq = $urandom;
                     if (!behind_next(noise_seq))
                        noise_seq = noise_seq ^ 32'h8000_0000;
                     seg_bytes = LEN_W'($urandom_range(1, MAX_PAYLOAD));
                  end
                  default: begin
                     j         = $urandom_range(n - 1);
                     noise_seq = plan[j].seg_seq;
                     seg_bytes = plan[j].seg_len;
                  end
               endcase
               offer(noise_seq, seg_bytes, 0, '0, 1'b0);
               sent_random++;
            end
            offer(plan[k].seg_seq, plan[k].seg_len, 0, '0, 1'b0);
            sent_random++;
         end
      end

      // end of stream, then words the block must swallow silently
      offer($urandom, 11'd0, 0, '0, 1'b0);
      for (int k = 0; k < 4; k++)
         offer($urandom, LEN_W'($urandom_range(0, MAX_PAYLOAD)), 0, '0, 1'b0);
      req_valid <= 1'b0;

      while (awaited_words.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d headers in (%0d directed), %0d result words, %0d deliveries, %0d full drops",
               accepted, directed_rows.size(), results_seen, deliveries, drops_seen);
      $display("idle mixes 34/61, 61/34 and none, one long result hold-off, stream closed");
      if (failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
